// ----- hw/rtl/rfbwp_pkg.sv -----
// shared types and constants of the blit window planner
`timescale 1ns / 1ps

package rfbwp_pkg;

    localparam int DimW   = 12;
    localparam int CoordW = 10;
    localparam int ColsW  = 9;
    localparam int RowsW  = 8;
    localparam int GlassW = 8;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLASS_X_OFFSET = 3'd2;
    localparam logic [2:0] REG_GLASS_Y_OFFSET = 3'd3;
    localparam logic [2:0] REG_PANEL_UP       = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FIT,
        ST_PREP,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_STORE,
        ST_FINISH,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_FIT,
        PH_DIV0,
        PH_DIV1
    } phase_t;

    typedef struct packed {
        logic   accept;
        logic   forget;
        logic   fit;
        logic   mul;
        logic   div_start;
        logic   store_fit;
        logic   store0;
        logic   store1;
        logic   draw;
        logic   drop;
        logic   out_load;
        phase_t phase;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic early_drop;
        logic need_fit;
        logic pic_bad;
        logic empty;
        logic div_busy;
    } dp_status_t;

endpackage

// ----- hw/rtl/rfbwp_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rfbwp_div #(
    parameter int DW = 23,
    parameter int VW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CntW = $clog2(DW + 1);

    logic [DW-1:0]   quot_reg, quot_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic [VW:0]     rem_shift;
    logic [VW:0]     diff;
    logic            ge;

    always_comb begin
        rem_shift = {rem_reg, quot_reg[DW-1]};
        diff      = rem_shift - {1'b0, divisor};
        ge        = (rem_shift >= {1'b0, divisor});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CntW'(DW);
            run_next  = 1'b1;
        end else if (run_reg) begin
            quot_next = {quot_reg[DW-2:0], ge};
            rem_next  = ge ? diff[VW-1:0] : rem_shift[VW-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy     = run_reg;
    assign quotient = quot_reg;

endmodule

// ----- hw/rtl/rfbwp_ctrl.sv -----
// sequencing state machine of the blit window planner
`timescale 1ns / 1ps

module rfbwp_ctrl
    import rfbwp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_FIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.phase     = phase_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.func) begin
                    cmd.forget = 1'b1;
                    cmd.drop   = 1'b1;
                    state_next = ST_OUT;
                end else if (status.early_drop) begin
                    cmd.drop   = 1'b1;
                    state_next = ST_OUT;
                end else if (status.need_fit) begin
                    state_next = ST_FIT;
                end else begin
                    state_next = ST_PREP;
                end
            end
            ST_FIT: begin
                cmd.fit    = 1'b1;
                phase_next = PH_FIT;
                state_next = ST_MUL;
            end
            ST_PREP: begin
                if (status.pic_bad) begin
                    cmd.drop   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    phase_next = PH_DIV0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                case (phase_reg)
                    PH_FIT: begin
                        cmd.store_fit = 1'b1;
                        state_next    = ST_PREP;
                    end
                    PH_DIV0: begin
                        cmd.store0 = 1'b1;
                        phase_next = PH_DIV1;
                        state_next = ST_MUL;
                    end
                    PH_DIV1: begin
                        cmd.store1 = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FINISH: begin
                if (status.empty) begin
                    cmd.drop = 1'b1;
                end else begin
                    cmd.draw = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/rfbwp_dp.sv -----
// fit, mapping and window tracking datapath
`timescale 1ns / 1ps

module rfbwp_dp
    import rfbwp_pkg::*;
#(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 172
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic              in_func,
    input  logic [DimW-1:0]   in_x,
    input  logic [DimW-1:0]   in_y,
    input  logic [DimW-1:0]   in_w,
    input  logic [DimW-1:0]   in_h,
    input  logic [DimW-1:0]   surface_width,
    input  logic [DimW-1:0]   surface_height,
    input  logic [GlassW-1:0] glass_x_offset,
    input  logic [GlassW-1:0] glass_y_offset,
    input  logic              panel_up,
    output logic              out_status,
    output logic              out_clear_first,
    output logic              out_new_window,
    output logic [CoordW-1:0] out_win_col_start,
    output logic [CoordW-1:0] out_win_row_start,
    output logic [CoordW-1:0] out_win_col_end,
    output logic [CoordW-1:0] out_win_row_end,
    output logic [ColsW-1:0]  out_cols,
    output logic [RowsW-1:0]  out_rows
);

    localparam int CW   = $clog2(PANEL_WIDTH + 1);
    localparam int RW   = $clog2(PANEL_HEIGHT + 1);
    localparam int PMax = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int NW   = $clog2(PMax + 1);
    localparam int AW   = DimW + 1;
    localparam int DW   = AW + NW;
    localparam int FW   = DimW + NW;

    // item
    logic            func_reg;
    logic [DimW-1:0] x_reg, y_reg, w_reg, h_reg;
    logic            cleared_reg;

    // fit
    logic [DimW-1:0] fitted_w_reg, fitted_h_reg;
    logic [NW-1:0]   scale_num_reg;
    logic [DimW-1:0] scale_den_reg;
    logic [CW-1:0]   pic_w_reg, margin_left_reg;
    logic [RW-1:0]   pic_h_reg, margin_top_reg;

    // tracked window
    logic [CW-1:0] track_col_start_reg, track_col_end_reg;
    logic [RW-1:0] track_row_end_reg, track_next_row_reg;
    logic          track_live_reg;

    // mapped rectangle
    logic [CW-1:0] ox0_reg, ox1_reg;
    logic [RW-1:0] oy0_reg, oy1_reg;

    // divider lanes
    logic [AW-1:0] a0, a1;
    logic [DW-1:0] prod0_reg, prod1_reg;
    logic [DW-1:0] q0, q1;
    logic          busy0, busy1;

    // result held until the output slot frees
    logic              res_status_reg, res_clear_reg, res_new_reg;
    logic [CoordW-1:0] res_cs_reg, res_rs_reg, res_ce_reg, res_re_reg;
    logic [ColsW-1:0]  res_cols_reg;
    logic [RowsW-1:0]  res_rows_reg;

    logic [FW-1:0] cross_w, cross_h;
    logic          take_w;
    logic [CW-1:0] pw_c, ox_c;
    logic [RW-1:0] ph_c, oy_c;
    logic [CW-1:0] cx0, cx1, cols;
    logic [RW-1:0] cy0, cy1, rows, base_row, row_end_new;
    logic [RW:0]   next_row;
    logic          fresh;

    always_comb begin
        cross_w = FW'(PANEL_WIDTH) * FW'(surface_height);
        cross_h = FW'(PANEL_HEIGHT) * FW'(surface_width);
        take_w  = (cross_w <= cross_h);
        case (cmd.phase)
            PH_DIV0: begin
                a0 = AW'(x_reg);
                a1 = AW'(y_reg);
            end
            PH_DIV1: begin
                a0 = AW'(x_reg) + AW'(w_reg);
                a1 = AW'(y_reg) + AW'(h_reg);
            end
            default: begin
                a0 = AW'(fitted_w_reg);
                a1 = AW'(fitted_h_reg);
            end
        endcase
        pw_c = (q0 > DW'(PANEL_WIDTH)) ? CW'(PANEL_WIDTH) : CW'(q0);
        ph_c = (q1 > DW'(PANEL_HEIGHT)) ? RW'(PANEL_HEIGHT) : RW'(q1);
        ox_c = (q0 > DW'(pic_w_reg)) ? pic_w_reg : CW'(q0);
        oy_c = (q1 > DW'(pic_h_reg)) ? pic_h_reg : RW'(q1);

        cx0  = margin_left_reg + ox0_reg;
        cx1  = margin_left_reg + ox1_reg - 1'b1;
        cy0  = margin_top_reg + oy0_reg;
        cy1  = margin_top_reg + oy1_reg - 1'b1;
        cols = ox1_reg - ox0_reg;
        rows = oy1_reg - oy0_reg;
        fresh = !(track_live_reg && cx0 == track_col_start_reg
                  && cx1 == track_col_end_reg && cy0 == track_next_row_reg
                  && cy1 <= track_row_end_reg);
        base_row    = fresh ? cy0 : track_next_row_reg;
        row_end_new = fresh ? cy1 : track_row_end_reg;
        next_row    = (RW + 1)'(base_row) + (RW + 1)'(rows);
    end

    always_comb begin
        status.func       = func_reg;
        status.early_drop = !panel_up || w_reg == '0 || h_reg == '0;
        status.need_fit   = !(surface_width == fitted_w_reg && surface_height == fitted_h_reg)
                            && surface_width != '0 && surface_height != '0;
        status.pic_bad    = pic_w_reg == '0 || pic_h_reg == '0
                            || x_reg >= fitted_w_reg || y_reg >= fitted_h_reg;
        status.empty      = ox1_reg <= ox0_reg || oy1_reg <= oy0_reg;
        status.div_busy   = busy0 || busy1;
    end

    rfbwp_div #(.DW(DW), .VW(DimW)) u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod0_reg),
        .divisor  (scale_den_reg),
        .busy     (busy0),
        .quotient (q0)
    );

    rfbwp_div #(.DW(DW), .VW(DimW)) u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod1_reg),
        .divisor  (scale_den_reg),
        .busy     (busy1),
        .quotient (q1)
    );

    // state with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cleared_reg         <= 1'b0;
            fitted_w_reg        <= '0;
            fitted_h_reg        <= '0;
            scale_num_reg       <= NW'(1);
            scale_den_reg       <= DimW'(1);
            pic_w_reg           <= '0;
            pic_h_reg           <= '0;
            margin_left_reg     <= '0;
            margin_top_reg      <= '0;
            track_col_start_reg <= '0;
            track_col_end_reg   <= '0;
            track_row_end_reg   <= '0;
            track_next_row_reg  <= '0;
            track_live_reg      <= 1'b0;
        end else begin
            if (cmd.accept) begin
                cleared_reg <= 1'b0;
            end
            if (cmd.forget) begin
                track_live_reg <= 1'b0;
            end
            if (cmd.fit) begin
                cleared_reg    <= 1'b1;
                fitted_w_reg   <= surface_width;
                fitted_h_reg   <= surface_height;
                scale_num_reg  <= take_w ? NW'(PANEL_WIDTH) : NW'(PANEL_HEIGHT);
                scale_den_reg  <= take_w ? surface_width : surface_height;
                track_live_reg <= 1'b0;
            end
            if (cmd.store_fit) begin
                pic_w_reg       <= pw_c;
                pic_h_reg       <= ph_c;
                margin_left_reg <= (CW'(PANEL_WIDTH) - pw_c) >> 1;
                margin_top_reg  <= (RW'(PANEL_HEIGHT) - ph_c) >> 1;
            end
            if (cmd.draw) begin
                if (fresh) begin
                    track_col_start_reg <= cx0;
                    track_col_end_reg   <= cx1;
                    track_row_end_reg   <= cy1;
                end
                track_next_row_reg <= RW'(next_row);
                track_live_reg     <= !(next_row > (RW + 1)'(row_end_new));
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= in_func;
            x_reg    <= in_x;
            y_reg    <= in_y;
            w_reg    <= in_w;
            h_reg    <= in_h;
        end
        if (cmd.mul) begin
            prod0_reg <= DW'(a0) * DW'(scale_num_reg);
            prod1_reg <= DW'(a1) * DW'(scale_num_reg);
        end
        if (cmd.store0) begin
            ox0_reg <= ox_c;
            oy0_reg <= oy_c;
        end
        if (cmd.store1) begin
            ox1_reg <= ox_c;
            oy1_reg <= oy_c;
        end
        if (cmd.drop) begin
            res_status_reg <= 1'b1;
            res_clear_reg  <= cleared_reg;
            res_new_reg    <= 1'b0;
            res_cs_reg     <= '0;
            res_rs_reg     <= '0;
            res_ce_reg     <= '0;
            res_re_reg     <= '0;
            res_cols_reg   <= '0;
            res_rows_reg   <= '0;
        end
        if (cmd.draw) begin
            res_status_reg <= 1'b0;
            res_clear_reg  <= cleared_reg;
            res_new_reg    <= fresh;
            res_cs_reg     <= CoordW'(cx0) + CoordW'(glass_x_offset);
            res_rs_reg     <= CoordW'(cy0) + CoordW'(glass_y_offset);
            res_ce_reg     <= CoordW'(cx1) + CoordW'(glass_x_offset);
            res_re_reg     <= CoordW'(cy1) + CoordW'(glass_y_offset);
            res_cols_reg   <= ColsW'(cols);
            res_rows_reg   <= RowsW'(rows);
        end
        if (cmd.out_load) begin
            out_status        <= res_status_reg;
            out_clear_first   <= res_clear_reg;
            out_new_window    <= res_new_reg;
            out_win_col_start <= res_cs_reg;
            out_win_row_start <= res_rs_reg;
            out_win_col_end   <= res_ce_reg;
            out_win_row_end   <= res_re_reg;
            out_cols          <= res_cols_reg;
            out_rows          <= res_rows_reg;
        end
    end

endmodule

// ----- hw/rtl/ratio_fit_blit_window_planner_unit.sv -----
// Blit window planner: takes one blit rectangle or window-forget request at a
// time and returns one result per request. Each rectangle that reaches the
// mapping runs two division rounds, and one that triggers a refit of a changed
// surface size runs one more before them. The rounds use two restoring
// dividers (column and row lane), which produce one quotient bit per cycle of
// a 22-bit quotient. Forget requests and early drops go from the check straight
// to the output. Rectangles dropped at the fit check skip the mapping rounds,
// but after a refit they still run the fit round. The next request can be
// accepted in the cycle after a result is loaded. A new request is taken while
// the previous result still waits in the output register.
// Configuration is read and written over the register port; write it only
// while the block is idle.
`timescale 1ns / 1ps

module ratio_fit_blit_window_planner_unit
    import rfbwp_pkg::*;
#(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 172
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,   // rect_x, rect_y, rect_w, rect_h
    input  logic             s_tuser,   // func
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    // clear_first, new_window, win_col_start, win_row_start, win_col_end,
    // win_row_end, out_cols, out_rows, zero fill
    output logic [63:0]      m_tdata,
    output logic             m_tuser,   // status
    // register port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    logic [DimW-1:0]   surface_width_reg, surface_height_reg;
    logic [GlassW-1:0] glass_x_offset_reg, glass_y_offset_reg;
    logic              panel_up_reg;
    logic [2:0]        reg_index;
    logic              cfg_write;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic              out_status, out_clear_first, out_new_window;
    logic [CoordW-1:0] out_win_col_start, out_win_row_start;
    logic [CoordW-1:0] out_win_col_end, out_win_row_end;
    logic [ColsW-1:0]  out_cols;
    logic [RowsW-1:0]  out_rows;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            surface_width_reg  <= '0;
            surface_height_reg <= '0;
            glass_x_offset_reg <= '0;
            glass_y_offset_reg <= '0;
            panel_up_reg       <= 1'b0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SURFACE_WIDTH:  surface_width_reg  <= pwdata[DimW-1:0];
                REG_SURFACE_HEIGHT: surface_height_reg <= pwdata[DimW-1:0];
                REG_GLASS_X_OFFSET: glass_x_offset_reg <= pwdata[GlassW-1:0];
                REG_GLASS_Y_OFFSET: glass_y_offset_reg <= pwdata[GlassW-1:0];
                REG_PANEL_UP:       panel_up_reg       <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SURFACE_WIDTH:  prdata = DataW'(surface_width_reg);
            REG_SURFACE_HEIGHT: prdata = DataW'(surface_height_reg);
            REG_GLASS_X_OFFSET: prdata = DataW'(glass_x_offset_reg);
            REG_GLASS_Y_OFFSET: prdata = DataW'(glass_y_offset_reg);
            REG_PANEL_UP:       prdata = DataW'(panel_up_reg);
            default:            prdata = '0;
        endcase
    end

    rfbwp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfbwp_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_func           (s_tuser),
        .in_x              (s_tdata[11:0]),
        .in_y              (s_tdata[23:12]),
        .in_w              (s_tdata[35:24]),
        .in_h              (s_tdata[47:36]),
        .surface_width     (surface_width_reg),
        .surface_height    (surface_height_reg),
        .glass_x_offset    (glass_x_offset_reg),
        .glass_y_offset    (glass_y_offset_reg),
        .panel_up          (panel_up_reg),
        .out_status        (out_status),
        .out_clear_first   (out_clear_first),
        .out_new_window    (out_new_window),
        .out_win_col_start (out_win_col_start),
        .out_win_row_start (out_win_row_start),
        .out_win_col_end   (out_win_col_end),
        .out_win_row_end   (out_win_row_end),
        .out_cols          (out_cols),
        .out_rows          (out_rows)
    );

    assign m_tuser = out_status;
    assign m_tdata = {5'b0, out_rows, out_cols, out_win_row_end, out_win_col_end,
                      out_win_row_start, out_win_col_start, out_new_window,
                      out_clear_first};

endmodule

// ----- verif/tb_ratio_fit_blit_window_planner_unit.sv -----
// self-checking testbench for the blit window planner: directed cases, random phases, back-pressure
`timescale 1ns / 1ps

module tb_ratio_fit_blit_window_planner_unit;
    import rfbwp_pkg::*;

    localparam int unsigned PANEL_W = 320;
    localparam int unsigned PANEL_H = 172;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 240;
    localparam int unsigned DRAIN_CYCLES = 120;

    typedef struct packed {
        logic       status;
        logic       clear_first;
        logic       new_window;
        logic [9:0] col_start;
        logic [9:0] row_start;
        logic [9:0] col_end;
        logic [9:0] row_end;
        logic [8:0] cols;
        logic [7:0] rows;
    } plan_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [47:0]      s_tdata = '0;     // rect_x, rect_y, rect_w, rect_h
    logic             s_tuser = 1'b0;   // func
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // clear_first, new_window, win_col_start, win_row_start, win_col_end,
    // win_row_end, out_cols, out_rows, zero fill
    logic [63:0]      m_tdata;
    logic             m_tuser;          // status
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    // register copies
    int unsigned cfg_surf_w = 0, cfg_surf_h = 0, cfg_glass_x = 0, cfg_glass_y = 0;
    int unsigned cfg_panel_up = 0;
    // fit and tracked window
    int unsigned fit_w = 0, fit_h = 0, ratio_num = 1, ratio_den = 1;
    int unsigned pic_w = 0, pic_h = 0, pad_left = 0, pad_top = 0;
    int unsigned win_start = 0, win_end = 0, win_last_row = 0, win_next_row = 0;
    logic        win_live = 1'b0;

    plan_t       plans_due[$];
    int unsigned mismatches = 0;
    bit          idling_on = 1'b1;
    int unsigned hold_offs_asked = 0, hold_offs_served = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    ratio_fit_blit_window_planner_unit #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    function automatic plan_t plan_request(input logic func, input int unsigned x, y, w, h);
        plan_t       r;
        int unsigned ox0, oy0, ox1, oy1, cx0, cx1, cy0, cy1;
        logic        fresh;
        r = '0;
        r.status = 1'b1;
        if (func) begin
            win_live = 1'b0;
            return r;
        end
        if (cfg_panel_up == 0 || w == 0 || h == 0) return r;
        if ((cfg_surf_w != fit_w || cfg_surf_h != fit_h)
            && cfg_surf_w != 0 && cfg_surf_h != 0) begin
            fit_w = cfg_surf_w;
            fit_h = cfg_surf_h;
            if (PANEL_W * fit_h <= PANEL_H * fit_w) begin
                ratio_num = PANEL_W;
                ratio_den = fit_w;
            end else begin
                ratio_num = PANEL_H;
                ratio_den = fit_h;
            end
            pic_w = fit_w * ratio_num / ratio_den;
            pic_h = fit_h * ratio_num / ratio_den;
            if (pic_w > PANEL_W) pic_w = PANEL_W;
            if (pic_h > PANEL_H) pic_h = PANEL_H;
            pad_left = (PANEL_W - pic_w) / 2;
            pad_top = (PANEL_H - pic_h) / 2;
            win_live = 1'b0;
            r.clear_first = 1'b1;
        end
        if (pic_w == 0 || pic_h == 0) return r;
        if (x >= fit_w || y >= fit_h) return r;
        ox0 = x * ratio_num / ratio_den;
        oy0 = y * ratio_num / ratio_den;
        ox1 = (x + w) * ratio_num / ratio_den;
        oy1 = (y + h) * ratio_num / ratio_den;
        if (ox1 > pic_w) ox1 = pic_w;
        if (oy1 > pic_h) oy1 = pic_h;
        if (ox1 <= ox0 || oy1 <= oy0) return r;
        cx0 = pad_left + ox0;
        cx1 = pad_left + ox1 - 1;
        cy0 = pad_top + oy0;
        cy1 = pad_top + oy1 - 1;
        fresh = !(win_live && cx0 == win_start && cx1 == win_end &&
                  cy0 == win_next_row && cy1 <= win_last_row);
        if (fresh) begin
            win_start = cx0;
            win_end = cx1;
            win_last_row = cy1;
            win_next_row = cy0;
            win_live = 1'b1;
        end
        if (win_live) begin
            win_next_row = (win_next_row + oy1 - oy0) & 32'h3FF;
            if (win_next_row > win_last_row) win_live = 1'b0;
        end
        r.status = 1'b0;
        r.new_window = fresh;
        r.col_start = 10'(cx0 + cfg_glass_x);
        r.row_start = 10'(cy0 + cfg_glass_y);
        r.col_end = 10'(cx1 + cfg_glass_x);
        r.row_end = 10'(cy1 + cfg_glass_y);
        r.cols = 9'(ox1 - ox0);
        r.rows = 8'(oy1 - oy0);
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(input logic func, input logic [11:0] x, y, w, h);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {h, w, y, x};
        do @(posedge aclk); while (!s_tready);
        plans_due.push_back(plan_request(func, 32'(x), 32'(y), 32'(w), 32'(h)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SURFACE_WIDTH:  cfg_surf_w = 32'(value[11:0]);
            REG_SURFACE_HEIGHT: cfg_surf_h = 32'(value[11:0]);
            REG_GLASS_X_OFFSET: cfg_glass_x = 32'(value[7:0]);
            REG_GLASS_Y_OFFSET: cfg_glass_y = 32'(value[7:0]);
            REG_PANEL_UP:       cfg_panel_up = 32'(value[0]);
            default: ;
        endcase
    endtask

    task automatic set_surface(input int unsigned sw, sh);
        write_reg(REG_SURFACE_WIDTH, sw);
        write_reg(REG_SURFACE_HEIGHT, sh);
    endtask

    // wait until every request has been answered and the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (plans_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random_rects(input int unsigned count);
        int unsigned sw, sh, pick, band_y, band_h;
        logic [11:0] x, y, w, h;
        logic        func;
        sw = (cfg_surf_w != 0 && cfg_surf_h != 0) ? cfg_surf_w : fit_w;
        sh = (cfg_surf_w != 0 && cfg_surf_h != 0) ? cfg_surf_h : fit_h;
        band_y = 0;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            func = (pick < 5);
            x = 12'($urandom);
            y = 12'($urandom);
            w = 12'($urandom);
            h = 12'($urandom);
            if (sw != 0 && sh != 0 && pick < 40) begin
                // full-width bands walking down the surface
                band_h = $urandom_range(1, (sh < 64) ? sh : 64);
                if (band_y >= sh) band_y = 0;
                x = '0;
                y = 12'(band_y);
                w = 12'(sw);
                h = 12'(band_h);
                band_y += band_h;
            end else if (sw != 0 && sh != 0 && pick < 85) begin
                x = 12'($urandom_range(0, sw - 1));
                y = 12'($urandom_range(0, sh - 1));
                w = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(1, 4095))
                                                : 12'($urandom_range(1, sw - x));
                h = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(1, 4095))
                                                : 12'($urandom_range(1, sh - y));
            end
            send_request(func, x, y, w, h);
        end
    endtask

    task automatic test_reset_state();
        send_request(1'b0, 12'd0, 12'd0, 12'd1, 12'd1);
        send_request(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
        settle();
        write_reg(REG_PANEL_UP, 1);
        send_request(1'b0, 12'd0, 12'd0, 12'd10, 12'd10);
        settle();
    endtask

    task automatic test_directed_cases();
        set_surface(PANEL_W, PANEL_H);
        write_reg(REG_GLASS_X_OFFSET, 0);
        write_reg(REG_GLASS_Y_OFFSET, 0);
        send_request(1'b0, 12'd0, 12'd0, 12'd320, 12'd172);
        send_request(1'b0, 12'd0, 12'd0, 12'd0, 12'd5);
        send_request(1'b0, 12'd0, 12'd0, 12'd5, 12'd0);
        send_request(1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_request(1'b0, 12'd319, 12'd171, 12'd4095, 12'd4095);
        send_request(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        settle();
        write_reg(REG_GLASS_X_OFFSET, 255);
        write_reg(REG_GLASS_Y_OFFSET, 255);
        send_request(1'b0, 12'd0, 12'd0, 12'd320, 12'd172);
        settle();
        // refit whose first rectangle falls outside, then an empty mapping
        set_surface(640, 344);
        send_request(1'b0, 12'd700, 12'd0, 12'd10, 12'd10);
        send_request(1'b0, 12'd0, 12'd0, 12'd1, 12'd1);
        send_request(1'b0, 12'd0, 12'd0, 12'd2, 12'd2);
        settle();
        // zero surface register keeps the earlier fit
        write_reg(REG_SURFACE_WIDTH, 0);
        send_request(1'b0, 12'd0, 12'd0, 12'd2, 12'd2);
        settle();
        set_surface(4095, 4095);
        send_request(1'b0, 12'd0, 12'd0, 12'd1, 12'd1);
        send_request(1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095);
        send_request(1'b0, 12'd4094, 12'd4094, 12'd1, 12'd1);
        send_request(1'b0, 12'd2000, 12'd100, 12'd300, 12'd40);
        settle();
        set_surface(4095, 1);
        send_request(1'b0, 12'd0, 12'd0, 12'd4095, 12'd1);
        settle();
        set_surface(1, 4095);
        send_request(1'b0, 12'd0, 12'd0, 12'd1, 12'd4095);
        settle();
    endtask

    task automatic test_random_settings();
        int unsigned sw, sh;
        for (int i = 0; i < 10; i++) begin
            case (i)
                0: begin sw = 1; sh = 1; end
                1: begin sw = 4095; sh = 4095; end
                2: begin sw = 4095; sh = 1; end
                3: begin sw = 1; sh = 4095; end
                4: begin sw = PANEL_W; sh = PANEL_H; end
                5: begin sw = 8; sh = 8; end
                6: begin sw = 0; sh = $urandom_range(1, 4095); end
                8: begin sw = $urandom_range(1, 64); sh = $urandom_range(1, 64); end
                default: begin sw = $urandom_range(1, 4095); sh = $urandom_range(1, 4095); end
            endcase
            set_surface(sw, sh);
            write_reg(REG_GLASS_X_OFFSET,
                      (i % 3 == 0) ? 0 : (i % 3 == 1) ? 255 : $urandom_range(0, 255));
            write_reg(REG_GLASS_Y_OFFSET,
                      (i % 3 == 0) ? 0 : (i % 3 == 1) ? 255 : $urandom_range(0, 255));
            write_reg(REG_PANEL_UP, (i == 7) ? 0 : 1);
            send_random_rects((i == 7) ? 30 : 145);
            settle();
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        set_surface($urandom_range(100, 900), $urandom_range(100, 900));
        write_reg(REG_PANEL_UP, 1);
        hold_offs_asked++;
        send_random_rects(60);
        settle();
    endtask

    task automatic test_streaming_tail();
        idling_on = 1'b0;
        set_surface($urandom_range(1, 4095), $urandom_range(1, 4095));
        send_random_rects(280);
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_offs_served != hold_offs_asked) begin
            hold_offs_served++;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        plan_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (plans_due.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = plans_due.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("clear_first", 32'(want.clear_first), 32'(m_tdata[0]));
                check_field("new_window", 32'(want.new_window), 32'(m_tdata[1]));
                check_field("win_col_start", 32'(want.col_start), 32'(m_tdata[11:2]));
                check_field("win_row_start", 32'(want.row_start), 32'(m_tdata[21:12]));
                check_field("win_col_end", 32'(want.col_end), 32'(m_tdata[31:22]));
                check_field("win_row_end", 32'(want.row_end), 32'(m_tdata[41:32]));
                check_field("out_cols", 32'(want.cols), 32'(m_tdata[50:42]));
                check_field("out_rows", 32'(want.rows), 32'(m_tdata[58:51]));
                check_field("zero fill", 0, 32'(m_tdata[63:59]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_cases();
        test_random_settings();
        test_backpressure();
        test_streaming_tail();
        while (plans_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
